FILE: hdl/w64sce_pkg.sv
`timescale 1ns / 1ps

package w64sce_pkg;

  localparam int unsigned SymW   = 6;
  localparam int unsigned SeedW  = 32;
  localparam int unsigned WordW  = 32;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 64;

  localparam logic [WordW-1:0] ScrFallback = 32'hDEAD_BEEF;

  // beat kind carried on in_tuser
  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_RESEED = 1'b1
  } kind_t;

  // one xorshift32 step (13, 17, 5) with zero replaced by the fallback
  function automatic logic [WordW-1:0] xorshift_step(input logic [WordW-1:0] s);
    logic [WordW-1:0] v;
    v = s;
    v = v ^ (v << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    if (v == '0) begin
      v = ScrFallback;
    end
    return v;
  endfunction

  // seed load value, zero maps to the fallback
  function automatic logic [WordW-1:0] seed_map(input logic [SeedW-1:0] seed);
    return (seed == '0) ? ScrFallback : seed;
  endfunction

  // one half of a 64-chip walsh row; chip k of the half sits at bit 31-k
  function automatic logic [WordW-1:0] walsh_half(input logic [SymW-1:0] sym,
                                                 input logic hi_half_sel);
    logic [WordW-1:0] w;
    logic [SymW-1:0]  j;
    w = '0;
    for (int k = 0; k < WordW; k++) begin
      j = {hi_half_sel, 5'(k)};
      w[WordW-1-k] = ~(^(sym & j));
    end
    return w;
  endfunction

endpackage

FILE: hdl/walsh64_scrambled_chip_encoder_unit.sv
`timescale 1ns / 1ps

// Walsh-64 chip encoder with xorshift32 scrambling. An encode beat (in_tuser = 0) spreads
// a 6-bit symbol into a 64-chip Walsh-Hadamard row (chip j is 1 when parity(symbol & j) is
// even, chip 0 at out_tdata[31]) and XORs chips 0..31 and 32..63 with two successive
// xorshift32 states; a reseed beat (in_tuser = 1) loads the scrambler state and emits no
// output beat. The block takes one beat per cycle except while an encode beat waits on a
// full result register that out_tready does not drain; an encode beat passes through the input
// register and then the result register. Both walsh halves and the two chained xorshift steps sit in the single stage
// between those registers. Reset loads the scrambler with 0xDEADBEEF, and a zero seed or
// a zero xorshift result is replaced by that value.
module walsh64_scrambled_chip_encoder_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [w64sce_pkg::InDataW-1:0]       in_tdata,   // symbol[5:0], seed[37:6], zero pad
  input  logic                                 in_tuser,   // kind: 0 encode, 1 reseed
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [w64sce_pkg::OutDataW-1:0]      out_tdata   // chips_high[31:0], chips_low[63:32]
);

  import w64sce_pkg::*;

  logic                 in_valid_r;
  kind_t                in_kind_r;
  logic [SymW-1:0]      in_sym_r;
  logic [SeedW-1:0]     in_seed_r;
  logic [WordW-1:0]     scr_state_r;
  logic [WordW-1:0]     scr_state_nxt;
  logic                 out_valid_r;
  logic [WordW-1:0]     chips_hi_r;
  logic [WordW-1:0]     chips_lo_r;
  logic [WordW-1:0]     key_hi;
  logic [WordW-1:0]     key_lo;
  logic                 advance;
  logic                 is_encode;

  // the input stage moves on unless an encode beat finds the result register blocked
  assign is_encode = (in_kind_r == KIND_ENCODE);
  assign advance   = in_valid_r && (!is_encode || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // two chained scrambler steps
  assign key_hi = xorshift_step(scr_state_r);
  assign key_lo = xorshift_step(key_hi);

  // scrambler state update
  always_comb begin
    scr_state_nxt = scr_state_r;
    if (advance) begin
      scr_state_nxt = is_encode ? key_lo : seed_map(in_seed_r);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r <= kind_t'(in_tuser);
      in_sym_r  <= in_tdata[SymW-1:0];
      in_seed_r <= in_tdata[SymW+SeedW-1:SymW];
    end
  end

  // scrambler state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_state_r <= ScrFallback;
    end else begin
      scr_state_r <= scr_state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && is_encode) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_encode) begin
      chips_hi_r <= walsh_half(in_sym_r, 1'b0) ^ key_hi;
      chips_lo_r <= walsh_half(in_sym_r, 1'b1) ^ key_lo;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {chips_lo_r, chips_hi_r};

  // scrambler state never reaches zero
  assert property (@(posedge clk) disable iff (!rst_n) scr_state_r != '0)
    else $error("scrambler state is zero");

  // a reseed beat leaving the input stage loads the mapped seed
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !is_encode) |=> (scr_state_r == $past(seed_map(in_seed_r))))
    else $error("reseed did not load the scrambler state");

  // an encode beat leaving the input stage fills the result register
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_encode) |=> out_valid_r)
    else $error("encode beat lost");

  // input back-pressure only when both stages are occupied
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without cause");

endmodule
